@@ hdl/gkl_pkg.sv @@
// Package for the Gaussian KL loss/gradient block: widths, constants, commands.
// No dependencies.
package gkl_pkg;
  localparam int unsigned InW   = 16;
  localparam int unsigned GradW = 32;
  localparam int unsigned LossW = 48;
  localparam int unsigned IbW   = 17;
  localparam int unsigned LwW   = 16;

  localparam logic [0:0] CFG_INV_BATCH   = 1'b0;
  localparam logic [0:0] CFG_LOSS_WEIGHT = 1'b1;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [16:0] ONE_Q16   = 17'd65536;

  // Datapath step commands
  typedef struct packed {
    logic load;    // capture inputs, clamp, start exp
    logic step;    // advance one datapath stage
    logic [2:0] phase;
  } gkl_cmd_t;
endpackage

@@ hdl/gkl_datapath.sv @@
// Datapath: exp approximation, term sum, loss and gradient products.
// Depends on gkl_pkg. One stage of work per phase under controller command.
module gkl_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gkl_pkg::gkl_cmd_t        cmd,
  input  logic signed [15:0]       mean_val,
  input  logic signed [15:0]       log_var,
  input  logic                     last_elem,
  input  logic [16:0]              inv_batch,
  input  logic signed [15:0]       loss_weight,
  output logic signed [31:0]       grad_mean,
  output logic signed [31:0]       grad_log_var,
  output logic [47:0]              loss_out,
  output logic                     loss_valid
);
  logic signed [15:0] m_r;
  logic signed [15:0] s_r;
  logic               last_r;
  logic [31:0]        u_r;      // biased s*log2e, Q.27
  logic [16:0]        p_r;      // polynomial accumulator
  logic [32:0]        prod_r;   // p*f
  logic [31:0]        e_r;      // exp in Q16, below 2^28
  logic [31:0]        mm_r;
  logic signed [33:0] alpha_r;
  logic signed [49:0] gm_prod_r;
  logic signed [65:0] gv_prod_r;
  logic [47:0]        sum_r;
  logic [47:0]        loss_r;
  logic [31:0]        gm_r, gv_r;

  logic signed [15:0] s_cl;
  logic [15:0]        f;
  logic [4:0]         ip;
  logic signed [33:0] term;
  logic [48:0]        sum_add;
  logic [64:0]        lossp;
  logic [47:0]        sum_sel;
  logic signed [49:0] gm_sh;
  logic signed [65:0] gv_sh;

  assign f  = u_r[26:11];
  assign ip = u_r[31:27];

  always_comb begin
    if (log_var > 16'sd16384) s_cl = 16'sd16384;
    else if (log_var < -16'sd16384) s_cl = -16'sd16384;
    else s_cl = log_var;
  end

  // term = E + m*m/64 - 32s - 1
  assign term = $signed({2'b0, e_r}) + $signed({2'b0, mm_r >> 6})
              - ($signed({{18{s_r[15]}}, s_r}) <<< 5) - 34'sd65536;
  assign sum_add = {1'b0, sum_r} + {15'b0, (term[33] ? 33'd0 : term[32:0])};
  assign sum_sel = sum_add[48] ? {gkl_pkg::LossW{1'b1}} : sum_add[47:0];
  // loss product from the registered sum; the result always fits 48 bits
  assign lossp = {17'b0, sum_r} * {48'b0, inv_batch};
  assign gm_sh = gm_prod_r >>> 19;
  assign gv_sh = gv_prod_r >>> 25;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.step) begin
      unique case (cmd.phase)
        3'd0: begin
          p_r    <= 17'd5184;
          prod_r <= 33'({16'b0, 17'd5184} * {17'b0, f});
          mm_r   <= 32'(m_r * m_r);
          alpha_r <= 34'(loss_weight * $signed({1'b0, inv_batch}));
        end
        3'd1: begin
          p_r    <= 17'd14752 + 17'(prod_r >> 16);
          prod_r <= 33'({16'b0, 17'd14752 + 17'(prod_r >> 16)} * {17'b0, f});
        end
        3'd2: begin
          p_r    <= 17'd45600 + 17'(prod_r >> 16);
          prod_r <= 33'({16'b0, 17'd45600 + 17'(prod_r >> 16)} * {17'b0, f});
        end
        3'd3: begin
          p_r <= gkl_pkg::ONE_Q16 + 17'(prod_r >> 16);
          gm_prod_r <= 50'(alpha_r * m_r);
        end
        3'd4: begin
          if (ip >= 5'd12) e_r <= 32'({15'b0, p_r} << (ip - 5'd12));
          else e_r <= 32'({15'b0, p_r} >> (5'd12 - ip));
        end
        3'd5: begin
          gv_prod_r <= 66'(alpha_r * ($signed({2'b0, e_r}) - 34'sd65536));
          sum_r <= sum_sel;
        end
        default: begin
          // batch loss on the last element, then clear the sum
          if (last_r) begin
            loss_r <= lossp[64:17];
            sum_r  <= '0;
          end else loss_r <= '0;
          // saturate gradients
          if (gm_sh > 50'sd2147483647) gm_r <= 32'h7FFF_FFFF;
          else if (gm_sh < -50'sd2147483648) gm_r <= 32'h8000_0000;
          else gm_r <= gm_sh[31:0];
          if (gv_sh > 66'sd2147483647) gv_r <= 32'h7FFF_FFFF;
          else if (gv_sh < -66'sd2147483648) gv_r <= 32'h8000_0000;
          else gv_r <= gv_sh[31:0];
        end
      endcase
    end
  end

  // input capture and exp argument
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r    <= mean_val;
      s_r    <= s_cl;
      last_r <= last_elem;
      u_r    <= 32'(s_cl * $signed({1'b0, gkl_pkg::LOG2E_Q16})) + (32'd12 << 27);
    end
  end

  assign grad_mean    = gm_r;
  assign grad_log_var = gv_r;
  assign loss_out     = loss_r;
  assign loss_valid   = last_r;
endmodule

@@ hdl/gkl_ctrl.sv @@
// Controller: accepts a request, sequences datapath phases, holds the result.
// Depends on gkl_pkg.
module gkl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gkl_pkg::gkl_cmd_t cmd
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [2:0] ph_r, ph_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.step  = (state_r == ST_RUN);
  assign cmd.phase = ph_r;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin state_nxt = ST_RUN; ph_nxt = '0; end
      ST_RUN: begin
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd6) state_nxt = ST_OUT;
      end
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end
endmodule

@@ hdl/gaussian_kl_loss_and_gradient.sv @@
// Top level of the Gaussian KL loss and gradient block.
// Depends on gkl_pkg, gkl_ctrl, gkl_datapath.
//
//  channel | handshake            | payload
//  in      | in_valid/in_ready    | in_mean_val, in_log_var, in_last_elem
//  out     | out_valid/out_ready  | out_grad_mean, out_grad_log_var, out_loss_out, out_loss_valid
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// Result valid once the 7 datapath phases have run after the accepting edge (a
// three-step Horner exp polynomial on one multiplier chain, then shift, sum,
// loss and products). Results hold until out_ready; the next request is taken
// in the cycle after that, so no request is taken while a result is pending.
// Synchronous reset clears the sum and sets inv_batch=1.0, loss_weight=1.0.
module gaussian_kl_loss_and_gradient (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_mean_val,
  input  logic signed [15:0] in_log_var,
  input  logic               in_last_elem,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_grad_mean,
  output logic signed [31:0] out_grad_log_var,
  output logic [47:0]        out_loss_out,
  output logic               out_loss_valid,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data
);
  gkl_pkg::gkl_cmd_t cmd;
  logic [16:0]        inv_batch_r;
  logic signed [15:0] loss_weight_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_batch_r   <= 17'd65536;
      loss_weight_r <= 16'sd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gkl_pkg::CFG_INV_BATCH:   inv_batch_r   <= cfg_data;
        gkl_pkg::CFG_LOSS_WEIGHT: loss_weight_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  gkl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  gkl_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .mean_val(in_mean_val), .log_var(in_log_var), .last_elem(in_last_elem),
    .inv_batch(inv_batch_r), .loss_weight(loss_weight_r),
    .grad_mean(out_grad_mean), .grad_log_var(out_grad_log_var),
    .loss_out(out_loss_out), .loss_valid(out_loss_valid)
  );
endmodule

@@ tb/gkl_checker.sv @@
// Checker for the Gaussian KL loss/gradient block: watches the request and result
// channels, predicts each result and compares it. Depends on gkl_pkg.
module gkl_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_mean_val,
  input  logic signed [15:0] in_log_var,
  input  logic               in_last_elem,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_grad_mean,
  input  logic signed [31:0] out_grad_log_var,
  input  logic [47:0]        out_loss_out,
  input  logic               out_loss_valid,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 loss_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] gm;
    logic [31:0] glv;
    logic [47:0] loss;
    logic        lv;
  } kl_result_t;

  kl_result_t   kl_expected[$];
  logic [16:0]  inv_batch_q;
  logic signed [15:0] loss_weight_q;
  logic [47:0]  kl_sum;

  // Saturate to 32-bit signed
  function automatic logic [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  // Arithmetic right shift is a floor in SystemVerilog
  function automatic longint floor_div(input longint x, input int k);
    return x >>> k;
  endfunction

  // Q16 exp of a clamped Q4.11 value
  function automatic longint exp_approx(input longint s);
    longint u, p, f;
    int ip;
    u = s * 94548 + (longint'(12) << 27);
    ip = int'(u >> 27);
    f = (u >> 11) & 16'hffff;
    p = 5184;
    p = 14752 + ((p * f) >> 16);
    p = 45600 + ((p * f) >> 16);
    p = 65536 + ((p * f) >> 16);
    if (ip >= 12) return p << (ip - 12);
    return p >> (12 - ip);
  endfunction

  function automatic kl_result_t predict_kl(input logic signed [15:0] mv,
                                            input logic signed [15:0] lvar,
                                            input logic last);
    kl_result_t r;
    longint m, s, e, term, alpha;
    logic [63:0] acc, loss;
    m = mv;
    s = lvar;
    if (s > 16384) s = 16384;
    if (s < -16384) s = -16384;
    e = exp_approx(s);
    term = e + ((m * m) >>> 6) - s * 32 - 65536;
    if (term < 0) term = 0;
    acc = {16'd0, kl_sum} + term;
    if (acc > 64'hffff_ffff_ffff) acc = 64'hffff_ffff_ffff;
    kl_sum = acc[47:0];
    loss = 0;
    if (last) begin
      loss = (acc >> 17) * inv_batch_q + (((acc & 64'h1ffff) * inv_batch_q) >> 17);
      if (loss > 64'hffff_ffff_ffff) loss = 64'hffff_ffff_ffff;
      kl_sum = 0;
    end
    alpha = longint'(loss_weight_q) * longint'({47'd0, inv_batch_q});
    r.gm   = clip32(floor_div(alpha * m, 19));
    r.glv  = clip32(floor_div(alpha * (e - 65536), 25));
    r.loss = loss[47:0];
    r.lv   = last;
    return r;
  endfunction

  assign pending = kl_expected.size();

  always @(posedge clk) begin
    kl_result_t want;
    if (!rst_n) begin
      inv_batch_q   <= 17'd65536;
      loss_weight_q <= 16'sd256;
      kl_sum         = '0;
      kl_expected.delete();
      fail_count    <= 0;
      loss_count    <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gkl_pkg::CFG_INV_BATCH) inv_batch_q <= cfg_data;
        else loss_weight_q <= cfg_data[15:0];
      end
      // Compare a delivered result against the oldest prediction
      if (out_valid && out_ready) begin
        if (kl_expected.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result at %0t", $time);
        end else begin
          want = kl_expected.pop_front();
          if (out_loss_valid) loss_count <= loss_count + 1;
          if (want != {out_grad_mean, out_grad_log_var, out_loss_out, out_loss_valid}) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp gm=%h glv=%h loss=%h lv=%b got %h %h %h %b",
                       want.gm, want.glv, want.loss, want.lv, out_grad_mean,
                       out_grad_log_var, out_loss_out, out_loss_valid);
          end
        end
      end
      // Predict each accepted request
      if (in_valid && in_ready)
        kl_expected.push_back(predict_kl(in_mean_val, in_log_var, in_last_elem));
    end
  end

  final if (kl_expected.size() != 0) $display("%0d results never arrived", kl_expected.size());
endmodule

@@ tb/gaussian_kl_loss_and_gradient_tb.sv @@
// Top of the Gaussian KL loss/gradient testbench: clock, reset, stimulus, verdict.
// Depends on gkl_pkg, gkl_checker and the block under test.
module gaussian_kl_loss_and_gradient_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, in_last_elem = 0;
  logic signed [15:0] in_mean_val = 0, in_log_var = 0;
  logic out_valid, out_ready = 0, out_loss_valid;
  logic signed [31:0] out_grad_mean, out_grad_log_var;
  logic [47:0] out_loss_out;
  logic cfg_we = 0, cfg_index = gkl_pkg::CFG_INV_BATCH;
  logic [16:0] cfg_data = 0;
  int fail_count, pending, loss_count;
  int idle_cycles = 0, sent = 0, stall_mode = 0;

  gaussian_kl_loss_and_gradient DUT (.*);
  gkl_checker checker_i (.*);

  initial forever #4 clk = ~clk;

  // Receiver stall pattern, mode changes each phase
  always @(posedge clk) begin
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_req(input logic [15:0] mv, input logic [15:0] lvar, input logic last);
    in_valid <= 1'b1;
    in_mean_val <= mv;
    in_log_var <= lvar;
    in_last_elem <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic pause_req(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // One write, after which the enable is driven low again before returning
  task automatic write_reg(input logic idx, input logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Quiesce before touching registers
  task automatic drain();
    pause_req(1);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Mostly moderate log-variance, sometimes clamped extremes
  function automatic logic [15:0] rand_lv();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 36000)) - 18000);
    endcase
  endfunction

  task automatic random_phase(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        send_req(16'($urandom), rand_lv(), ($urandom_range(0, 7) == 0));
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) == 0) pause_req($urandom_range(1, 12));
    end
    send_req(16'($urandom), rand_lv(), 1'b1);
  endtask

  initial begin
    logic [16:0] ib_set[6];
    logic [15:0] lw_set[6];
    ib_set = '{17'd65536, 17'd1, 17'd0, 17'h1ffff, 17'd4096, 17'd32768};
    lw_set = '{16'd256, 16'h8000, 16'h7fff, 16'd0, 16'hff00, 16'd1000};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, clamp edges, near-zero term, a run of large terms
    send_req(16'h0000, 16'h0000, 1'b1);
    send_req(16'h7fff, 16'h7fff, 1'b0);
    send_req(16'h8000, 16'h8000, 1'b1);
    send_req(16'h0001, 16'd16384, 1'b0);
    send_req(16'hffff, 16'hc000, 1'b0);
    send_req(16'h0000, 16'd16385, 1'b0);
    send_req(16'h0000, 16'hbfff, 1'b1);
    send_req(16'h0010, 16'h0001, 1'b0);
    send_req(16'h0000, 16'hffff, 1'b1);
    for (int i = 0; i < 12; i++) send_req(16'h7fff, 16'd16384, 1'b0);
    send_req(16'h8000, 16'd16384, 1'b1);
    drain();

    // Sweep register settings, extremes included; random content in each
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      write_reg(gkl_pkg::CFG_INV_BATCH, ib_set[ph]);
      write_reg(gkl_pkg::CFG_LOSS_WEIGHT, {1'b0, lw_set[ph]});
      random_phase(280);
      drain();
    end
    stall_mode = 1;
    write_reg(gkl_pkg::CFG_INV_BATCH, 17'($urandom));
    write_reg(gkl_pkg::CFG_LOSS_WEIGHT, 17'($urandom));
    random_phase(30);
    drain();

    $display("run: %0d requests over 7 register settings, %0d batch losses checked",
             sent, loss_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
